@@ hdl/tcw_pkg.sv @@
// Shared constants, codes and types of the text console writer.
package tcw_pkg;

    // Default geometry
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TERMINALS = 3;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int TERM_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int LOC_W   = 11;
    localparam int ATTR_W  = 8;

    // Stream payload widths (tdata padded to whole bytes)
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = FUNC_W;
    localparam int M_TDATA_W = 32;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'h00;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // Write side of the cell store
    typedef struct packed {
        logic              we_char;
        logic              we_attr;
        logic [CHAR_W-1:0] wchar;
        logic [ATTR_W-1:0] wattr;
    } t_mem_req;

endpackage

@@ hdl/tcw_cell_store.sv @@
// Single-port character and attribute store with registered read data.
module tcw_cell_store #(
    parameter int DEPTH = tcw_pkg::DEF_COLUMNS * tcw_pkg::DEF_ROWS * tcw_pkg::DEF_TERMINALS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic [AW-1:0]               i_addr,
    input  tcw_pkg::t_mem_req           i_req,
    output logic [tcw_pkg::CHAR_W-1:0]  o_rd_char,
    output logic [tcw_pkg::ATTR_W-1:0]  o_rd_attr
);
    import tcw_pkg::*;

    logic [CHAR_W-1:0] r_char_mem [DEPTH];
    logic [ATTR_W-1:0] r_attr_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we_char) begin
            r_char_mem[i_addr] <= i_req.wchar;
        end
        o_rd_char <= r_char_mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_req.we_attr) begin
            r_attr_mem[i_addr] <= i_req.wattr;
        end
        o_rd_attr <= r_attr_mem[i_addr];
    end

endmodule

@@ hdl/text_console_writer_top.sv @@
// Text console writer: cursor handling and page sequencer over a shared cell store.
//
// Channel      Dir  Handshake                 Payload
// s_axis       in   tvalid/tready             tuser: func; tdata: terminal, char_code, cell_index
// m_axis       out  tvalid/tready             tdata: cursor_location, cell_char, cell_attr
// cfg          in   wr_en (no wait)           wr_data: text_attribute
//
// Read: decode, capture, done; put and newline: decode, execute, done; backspace adds a
// check of the cell before the cursor; clear sweeps the page. A scroll copies each row up
// (read, then write) and blanks the last row; the single store port and its address adder
// set the pace (one cell access per cycle). After reset the store is zeroed with tready low.
// tready is high only while the sequencer is idle; a finished result waits in the
// output register while the next transaction is taken.
module text_console_writer_top #(
    parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS      = tcw_pkg::DEF_ROWS,
    parameter int TERMINALS = tcw_pkg::DEF_TERMINALS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [1:0] terminal, [9:2] char_code, [20:10] cell_index, rest zero
    input  logic [tcw_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // [1:0] func
    input  logic [tcw_pkg::S_TUSER_W-1:0]   i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [10:0] cursor_location, [18:11] cell_char, [26:19] cell_attr, rest zero
    output logic [tcw_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    input  logic                            i_cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]      i_cfg_wr_data
);
    import tcw_pkg::*;

    localparam int PAGE_CELLS  = COLUMNS * ROWS;
    localparam int TOTAL_CELLS = PAGE_CELLS * TERMINALS;
    localparam int AW = $clog2(TOTAL_CELLS);
    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int TW = (TERMINALS > 1) ? $clog2(TERMINALS) : 1;

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_DECODE  = 4'd2;
    localparam logic [3:0] S_EXEC    = 4'd3;
    localparam logic [3:0] S_BS_CHK  = 4'd4;
    localparam logic [3:0] S_RD_CAP  = 4'd5;
    localparam logic [3:0] S_CLEAR   = 4'd6;
    localparam logic [3:0] S_SC_RD   = 4'd7;
    localparam logic [3:0] S_SC_WR   = 4'd8;
    localparam logic [3:0] S_SC_FILL = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]         r_state;
    logic [AW-1:0]      r_k;
    logic [ATTR_W-1:0]  r_attr;
    logic [FUNC_W-1:0]  r_func;
    logic [TERM_W-1:0]  r_term;
    logic [CHAR_W-1:0]  r_chr;
    logic [INDEX_W-1:0] r_idx;
    logic               r_bad;
    logic [AW-1:0]      r_base;
    logic [AW-1:0]      r_pos;
    logic [CHAR_W-1:0]  r_rc;
    logic [ATTR_W-1:0]  r_ra;
    logic [CW-1:0]      r_col [TERMINALS];
    logic [RW-1:0]      r_row [TERMINALS];
    logic               r_out_valid;
    logic [LOC_W-1:0]   r_out_loc;
    logic [CHAR_W-1:0]  r_out_char;
    logic [ATTR_W-1:0]  r_out_attr;

    logic               s_acc;
    logic [TW-1:0]      tix;
    logic [CW-1:0]      cur_col;
    logic [RW-1:0]      cur_row;
    logic [AW-1:0]      cur_pos;
    logic               last_row;
    logic               last_col;
    logic               is_newline;
    logic               is_bs;
    logic [AW-1:0]      ofs;
    logic [AW-1:0]      mem_addr;
    t_mem_req           mem_req;
    logic [CHAR_W-1:0]  rd_char;
    logic [ATTR_W-1:0]  rd_attr;
    logic               out_free;

    assign s_acc      = i_s_axis_tvalid && o_s_axis_tready;
    assign tix        = TW'(r_term);
    assign cur_col    = r_col[tix];
    assign cur_row    = r_row[tix];
    assign cur_pos    = AW'(32'(cur_row) * COLUMNS + 32'(cur_col));
    assign last_row   = (cur_row == RW'(ROWS - 1));
    assign last_col   = (cur_col == CW'(COLUMNS - 1));
    assign is_newline = (r_chr == CH_LF) || (r_chr == CH_CR);
    assign is_bs      = (r_chr == CH_BACKSPACE);
    assign out_free   = !r_out_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out_attr, r_out_char, r_out_loc};

    // Shared address unit: page base plus offset, except during the reset sweep
    always_comb begin
        ofs     = r_k;
        mem_req = '0;
        case (r_state)
            S_DECODE: begin
                ofs = AW'(r_idx);
            end
            S_EXEC: begin
                if (is_bs) begin
                    ofs = r_pos - AW'(1);
                end else begin
                    ofs = r_pos;
                    if (!is_newline) begin
                        mem_req.we_char = 1'b1;
                        mem_req.we_attr = 1'b1;
                        mem_req.wchar   = r_chr;
                        mem_req.wattr   = r_attr;
                    end
                end
            end
            S_BS_CHK: begin
                ofs             = r_pos - AW'(1);
                mem_req.we_char = (rd_char != CH_NUL);
                mem_req.wchar   = CH_NUL;
            end
            S_CLEAR: begin
                mem_req.we_char = 1'b1;
                mem_req.we_attr = 1'b1;
                mem_req.wchar   = CH_SPACE;
                mem_req.wattr   = r_attr;
            end
            S_SC_RD: begin
                ofs = r_k + AW'(COLUMNS);
            end
            S_SC_WR: begin
                mem_req.we_char = 1'b1;
                mem_req.wchar   = rd_char;
            end
            S_SC_FILL: begin
                mem_req.we_char = 1'b1;
                mem_req.wchar   = CH_SPACE;
            end
            S_INIT: begin
                mem_req.we_char = 1'b1;
                mem_req.we_attr = 1'b1;
            end
            default: begin
                ofs = r_k;
            end
        endcase
        mem_addr = (r_state == S_INIT) ? r_k : r_base + ofs;
    end

    tcw_cell_store #(
        .DEPTH (TOTAL_CELLS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_addr    (mem_addr),
        .i_req     (mem_req),
        .o_rd_char (rd_char),
        .o_rd_attr (rd_attr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_wr_en) begin
            r_attr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < TERMINALS; t++) begin
                r_col[t] <= '0;
                r_row[t] <= '0;
            end
        end else begin
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    if (r_k == AW'(TOTAL_CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_acc) begin
                        r_func  <= i_s_axis_tuser[FUNC_W-1:0];
                        r_term  <= i_s_axis_tdata[1:0];
                        r_chr   <= i_s_axis_tdata[9:2];
                        r_idx   <= i_s_axis_tdata[20:10];
                        r_bad   <= (32'(i_s_axis_tdata[1:0]) >= TERMINALS);
                        r_base  <= AW'(32'(i_s_axis_tdata[1:0]) * PAGE_CELLS);
                        r_rc    <= '0;
                        r_ra    <= '0;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    r_pos <= cur_pos;
                    r_k   <= '0;
                    if (r_bad) begin
                        r_state <= S_DONE;
                    end else begin
                        case (r_func)
                            FUNC_PUT:   r_state <= S_EXEC;
                            FUNC_CLEAR: r_state <= S_CLEAR;
                            FUNC_READ: begin
                                r_state <= (32'(r_idx) < PAGE_CELLS) ? S_RD_CAP : S_DONE;
                            end
                            default:    r_state <= S_DONE;
                        endcase
                    end
                end
                S_RD_CAP: begin
                    r_rc    <= rd_char;
                    r_ra    <= rd_attr;
                    r_state <= S_DONE;
                end
                S_EXEC: begin
                    r_state <= S_DONE;
                    if (is_bs) begin
                        if (r_pos != '0) begin
                            r_state <= S_BS_CHK;
                        end
                    end else if (is_newline || last_col) begin
                        // newline, or wrap past the last column
                        if (last_row) begin
                            r_state <= S_SC_RD;
                        end else begin
                            r_row[tix] <= cur_row + RW'(1);
                            r_col[tix] <= '0;
                        end
                    end else begin
                        r_col[tix] <= cur_col + CW'(1);
                    end
                end
                S_BS_CHK: begin
                    if (rd_char != CH_NUL) begin
                        if (cur_col == '0) begin
                            r_col[tix] <= CW'(COLUMNS - 1);
                            r_row[tix] <= cur_row - RW'(1);
                        end else begin
                            r_col[tix] <= cur_col - CW'(1);
                        end
                    end
                    r_state <= S_DONE;
                end
                S_CLEAR: begin
                    if (r_k == AW'(PAGE_CELLS - 1)) begin
                        r_col[tix] <= '0;
                        r_row[tix] <= '0;
                        r_state    <= S_DONE;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                S_SC_RD: begin
                    r_state <= S_SC_WR;
                end
                S_SC_WR: begin
                    if (r_k == AW'(PAGE_CELLS - COLUMNS - 1)) begin
                        r_state <= S_SC_FILL;
                    end else begin
                        r_state <= S_SC_RD;
                    end
                    r_k <= r_k + AW'(1);
                end
                S_SC_FILL: begin
                    // blank the last row and park the cursor at its start
                    if (r_k == AW'(PAGE_CELLS - 1)) begin
                        r_col[tix] <= '0;
                        r_row[tix] <= RW'(ROWS - 1);
                        r_state    <= S_DONE;
                    end else begin
                        r_k <= r_k + AW'(1);
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_loc   <= r_bad ? '0 : LOC_W'(cur_pos);
                        r_out_char  <= r_rc;
                        r_out_attr  <= r_ra;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_decodes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_state == S_DECODE)
        else $error("accepted transaction did not enter decode");

    a_done_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not loaded into output register");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !(mem_req.we_char || mem_req.we_attr))
        else $error("store written while no work is pending");

    a_cursor_in_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_bad) |-> (32'(cur_pos) < PAGE_CELLS))
        else $error("cursor left the page");

    a_scroll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SC_WR |-> (32'(r_k) < PAGE_CELLS - COLUMNS))
        else $error("scroll copy ran past the next to last row");
`endif

endmodule

@@ dv/tb_text_console_writer_top.sv @@
// Self-checking testbench for the text console writer top level.
`timescale 1ns / 1ps

module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam int COLS       = DEF_COLUMNS;
    localparam int ROWS       = DEF_ROWS;
    localparam int TERMS      = DEF_TERMINALS;
    localparam int PAGE       = COLS * ROWS;
    localparam int RAND_ITEMS = 420;
    localparam int PHASE_LEN  = 60;
    localparam int HOLD_LEN   = 400;
    // worst single transaction is a scroll plus a clear-sized margin and long idles
    localparam int CYCLE_LIMIT = TERMS * PAGE
        + 800 * (2 * (ROWS - 1) * COLS + COLS + PAGE + 200) * 3;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam logic [TERM_W-1:0] TERM_BAD    = 2'd3;

    typedef struct packed {
        logic [ATTR_W-1:0] attr;
        logic [CHAR_W-1:0] chr;
        logic [LOC_W-1:0]  loc;
    } t_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic [S_TUSER_W-1:0]  i_s_axis_tuser = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]     i_cfg_wr_data = '0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;

    // console model state
    logic [CHAR_W-1:0] char_mem [TERMS*PAGE];
    logic [ATTR_W-1:0] attr_mem [TERMS*PAGE];
    int                cur_col  [TERMS];
    int                cur_row  [TERMS];
    logic [ATTR_W-1:0] text_attr;

    t_reply predicted_replies[$];
    int     fail_count = 0;
    int     cycles = 0;
    bit     tx_gaps_on = 1'b0;
    bit     rx_gaps_on = 1'b0;
    int     hold_asks = 0;
    int     hold_seen = 0;
    int     hold_left = 0;
    int     stall_left = 0;

    always #5 i_clk = ~i_clk;

    text_console_writer_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data)
    );

    function automatic void reset_console();
        for (int k = 0; k < TERMS * PAGE; k++) begin
            char_mem[k] = '0;
            attr_mem[k] = '0;
        end
        for (int t = 0; t < TERMS; t++) begin
            cur_col[t] = 0;
            cur_row[t] = 0;
        end
        text_attr = ATTR_RESET;
    endfunction

    function automatic void scroll_page(int term);
        int base;
        base = term * PAGE;
        for (int k = 0; k + COLS < PAGE; k++)
            char_mem[base + k] = char_mem[base + k + COLS];
        for (int k = PAGE - COLS; k < PAGE; k++)
            char_mem[base + k] = CH_SPACE;
        cur_col[term] = 0;
        cur_row[term] = ROWS - 1;
    endfunction

    function automatic void next_line(int term);
        if (cur_row[term] == ROWS - 1) begin
            scroll_page(term);
        end else begin
            cur_row[term] = cur_row[term] + 1;
            cur_col[term] = 0;
        end
    endfunction

    // Apply one transaction to the console state and return the reply it produces.
    function automatic t_reply console_step(logic [FUNC_W-1:0] fn, logic [TERM_W-1:0] term,
                                            logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
        t_reply r;
        int     t;
        int     base;
        int     pos;
        r = '0;
        t = int'(term);
        if (t >= TERMS)
            return r;
        base = t * PAGE;
        pos = cur_row[t] * COLS + cur_col[t];
        case (fn)
            FUNC_PUT: begin
                if (ch == CH_LF || ch == CH_CR) begin
                    next_line(t);
                end else if (ch == CH_BACKSPACE) begin
                    // erase only a nonzero cell; the origin has no cell before it
                    if (pos != 0 && char_mem[base + pos - 1] != CH_NUL) begin
                        char_mem[base + pos - 1] = CH_NUL;
                        if (cur_col[t] == 0) begin
                            cur_col[t] = COLS - 1;
                            cur_row[t] = cur_row[t] - 1;
                        end else begin
                            cur_col[t] = cur_col[t] - 1;
                        end
                    end
                end else begin
                    char_mem[base + pos] = ch;
                    attr_mem[base + pos] = text_attr;
                    if (cur_col[t] == COLS - 1)
                        next_line(t);
                    else
                        cur_col[t] = cur_col[t] + 1;
                end
            end
            FUNC_CLEAR: begin
                for (int k = 0; k < PAGE; k++) begin
                    char_mem[base + k] = CH_SPACE;
                    attr_mem[base + k] = text_attr;
                end
                cur_col[t] = 0;
                cur_row[t] = 0;
            end
            FUNC_READ: begin
                if (int'(idx) < PAGE) begin
                    r.chr = char_mem[base + int'(idx)];
                    r.attr = attr_mem[base + int'(idx)];
                end
            end
            default: ;
        endcase
        r.loc = LOC_W'(cur_row[t] * COLS + cur_col[t]);
        return r;
    endfunction

    function automatic int pick_idle(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 45);
    endfunction

    function automatic logic [CHAR_W-1:0] plain_byte();
        logic [CHAR_W-1:0] c;
        c = CH_BACKSPACE;
        while (c == CH_BACKSPACE || c == CH_LF || c == CH_CR)
            c = CHAR_W'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < 40)
            $display("%0t ns: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    task automatic send_item(logic [FUNC_W-1:0] fn, logic [TERM_W-1:0] term,
                             logic [CHAR_W-1:0] ch, logic [INDEX_W-1:0] idx);
        int gap;
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {3'b000, idx, ch, term};
        i_s_axis_tuser <= fn;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        predicted_replies.push_back(console_step(fn, term, ch, idx));
        gap = pick_idle(tx_gaps_on);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain_replies();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
        while (predicted_replies.size() != 0)
            @(posedge i_clk);
    endtask

    // Write the attribute register once the block has gone idle.
    task automatic set_text_attribute(logic [ATTR_W-1:0] value);
        drain_replies();
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        text_attr = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Receiver: random stalls, plus long hold-offs requested by a test.
    always @(negedge i_clk) begin
        if (hold_asks != hold_seen) begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_LEN - 1;
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_gaps_on && $urandom_range(0, 99) < 30) begin
            stall_left <= pick_idle(1'b1);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (predicted_replies.size() == 0) begin
                report_mismatch("unexpected reply, tdata", int'(o_m_axis_tdata), 0);
            end else begin
                want = predicted_replies.pop_front();
                if (o_m_axis_tdata[10:0] !== want.loc)
                    report_mismatch("cursor_location", int'(o_m_axis_tdata[10:0]),
                                    int'(want.loc));
                if (o_m_axis_tdata[18:11] !== want.chr)
                    report_mismatch("cell_char", int'(o_m_axis_tdata[18:11]),
                                    int'(want.chr));
                if (o_m_axis_tdata[26:19] !== want.attr)
                    report_mismatch("cell_attr", int'(o_m_axis_tdata[26:19]),
                                    int'(want.attr));
                if (o_m_axis_tdata[31:27] !== 5'd0)
                    report_mismatch("tdata padding", int'(o_m_axis_tdata[31:27]), 0);
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb_text_console_writer_top: errors");
        $finish;
    end

    // Reads of the zeroed store and range edges, bad-terminal items, an unused function and a backspace at the origin.
    task automatic test_startup_reads();
        send_item(FUNC_READ, 2'd0, 8'h00, 11'd0);
        send_item(FUNC_READ, 2'd2, 8'hFF, 11'd1999);
        send_item(FUNC_READ, 2'd1, 8'h00, 11'd2000);
        send_item(FUNC_READ, 2'd0, 8'h00, 11'd2047);
        send_item(FUNC_UNUSED, 2'd1, 8'hFF, 11'd2047);
        send_item(FUNC_PUT, TERM_BAD, 8'hFF, 11'd0);
        send_item(FUNC_CLEAR, TERM_BAD, 8'h00, 11'd0);
        send_item(FUNC_READ, TERM_BAD, 8'h00, 11'd5);
        send_item(FUNC_PUT, 2'd0, CH_BACKSPACE, 11'd0);
    endtask

    task automatic test_put_edges();
        set_text_attribute(8'hFF);
        send_item(FUNC_PUT, 2'd0, 8'h00, 11'd0);
        send_item(FUNC_PUT, 2'd0, CH_BACKSPACE, 11'd0);    // zero cell: no change
        send_item(FUNC_PUT, 2'd0, 8'hFF, 11'd0);
        send_item(FUNC_PUT, 2'd0, 8'h41, 11'd0);
        send_item(FUNC_PUT, 2'd0, CH_BACKSPACE, 11'd0);
        send_item(FUNC_READ, 2'd0, 8'h00, 11'd2);
        send_item(FUNC_READ, 2'd0, 8'h00, 11'd1);
        send_item(FUNC_PUT, 2'd0, CH_LF, 11'd0);
        send_item(FUNC_PUT, 2'd0, CH_BACKSPACE, 11'd0);    // row above ends in zero
        send_item(FUNC_PUT, 2'd0, CH_CR, 11'd0);
        send_item(FUNC_READ, 2'd0, 8'h00, 11'd0);
        send_item(FUNC_CLEAR, 2'd2, 8'h00, 11'd0);
        send_item(FUNC_READ, 2'd2, 8'h00, 11'd1999);
        send_item(FUNC_PUT, 2'd2, CH_LF, 11'd0);
        send_item(FUNC_PUT, 2'd2, CH_BACKSPACE, 11'd0);    // wraps back onto a space
        send_item(FUNC_READ, 2'd2, 8'h00, 11'd79);
    endtask

    // Drive one terminal to the bottom row, then wrap and scroll.
    task automatic test_scroll();
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        set_text_attribute(8'h00);
        for (int n = 0; n < ROWS - 1; n++) begin
            repeat ($urandom_range(0, 3))
                send_item(FUNC_PUT, 2'd1, plain_byte(), 11'($urandom));
            send_item(FUNC_PUT, 2'd1, $urandom_range(0, 1) ? CH_LF : CH_CR, 11'($urandom));
        end
        for (int n = 0; n < COLS; n++)
            send_item(FUNC_PUT, 2'd1, plain_byte(), 11'($urandom));
        for (int n = 0; n < 3; n++) begin
            send_item(FUNC_READ, 2'd1, 8'h00, 11'(PAGE - 1 - $urandom_range(0, COLS - 1)));
            send_item(FUNC_READ, 2'd1, 8'h00, 11'(PAGE - 1 - $urandom_range(COLS, 4 * COLS)));
        end
        send_item(FUNC_PUT, 2'd1, CH_LF, 11'd0);
        send_item(FUNC_PUT, 2'd1, CH_BACKSPACE, 11'd0);
        send_item(FUNC_PUT, 2'd1, CH_BACKSPACE, 11'd0);
        send_item(FUNC_READ, 2'd1, 8'h00, 11'(PAGE - COLS - 1));
    endtask

    // Hold the reply side off while items keep coming so the input stalls.
    task automatic test_backpressure();
        set_text_attribute(8'h5A);
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_asks++;
        for (int n = 0; n < 8; n++)
            send_item(FUNC_PUT, 2'd0, plain_byte(), 11'd0);
        send_item(FUNC_READ, 2'd0, 8'h00, 11'd0);
    endtask

    task automatic test_random_text();
        int                 sel;
        int                 pick;
        int                 loc;
        logic [TERM_W-1:0]  term;
        logic [FUNC_W-1:0]  fn;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        for (int phase = 0; phase < RAND_ITEMS / PHASE_LEN; phase++) begin
            case (phase % 4)
                0: set_text_attribute(8'h00);
                1: set_text_attribute(8'hFF);
                default: set_text_attribute(ATTR_W'($urandom));
            endcase
            tx_gaps_on = (phase % 4 != 3) && (phase % 3 != 2);
            rx_gaps_on = (phase % 4 != 3) && (phase % 3 != 1);
            for (int n = 0; n < PHASE_LEN; n++) begin
                term = ($urandom_range(0, 19) == 0) ? TERM_BAD : TERM_W'($urandom_range(0, 2));
                ch = CHAR_W'($urandom_range(0, 255));
                idx = INDEX_W'($urandom);
                sel = $urandom_range(0, 99);
                if (sel < 74) begin
                    fn = FUNC_PUT;
                    pick = $urandom_range(0, 99);
                    if (pick < 18)
                        ch = $urandom_range(0, 1) ? CH_LF : CH_CR;
                    else if (pick < 30)
                        ch = CH_BACKSPACE;
                end else if (sel < 94) begin
                    fn = FUNC_READ;
                    pick = $urandom_range(0, 99);
                    loc = (term == TERM_BAD) ? 0 : cur_row[term] * COLS + cur_col[term];
                    if (pick < 50) begin
                        loc = loc - $urandom_range(0, 90);
                        idx = (loc < 0) ? 11'd0 : INDEX_W'(loc);
                    end else if (pick < 85) begin
                        idx = INDEX_W'($urandom_range(0, PAGE - 1));
                    end
                end else if (sel < 96) begin
                    fn = FUNC_CLEAR;
                end else begin
                    fn = FUNC_UNUSED;
                end
                send_item(fn, term, ch, idx);
            end
        end
        set_text_attribute(ATTR_RESET);
        send_item(FUNC_PUT, 2'd2, 8'h7E, 11'd0);
        send_item(FUNC_READ, 2'd2, 8'h00, 11'(cur_row[2] * COLS + cur_col[2] - 1));
        drain_replies();
    endtask

    initial begin
        reset_console();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_startup_reads();
        test_put_edges();
        test_scroll();
        test_backpressure();
        test_random_text();
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_text_console_writer_top: clean");
        else
            $display("tb_text_console_writer_top: errors");
        $finish;
    end

endmodule
